// ===== design/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types and constants of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int KEY_COUNT_DEF  = 4;
    localparam int KEY_IDX_W      = 2;
    localparam int TICK_W         = 32;
    localparam int THRESH_W       = 16;
    localparam int EVENT_W        = 2;
    localparam int CFG_ADDR_W     = 1;

    localparam logic [THRESH_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [THRESH_W-1:0] LONG_RESET     = 16'd500;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG     = 1'd1;

    // event and pending action codes
    localparam logic [EVENT_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EVT_SHORT = 2'd1;
    localparam logic [EVENT_W-1:0] EVT_LONG  = 2'd2;

    // stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = KEY_IDX_W + 1 + TICK_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((EVENT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [THRESH_W-1:0] debounce_ticks;
        logic [THRESH_W-1:0] long_press_ticks;
    } cfg_t;

endpackage

// ===== design/kpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kpc_cfg_regs
// Threshold registers written through the plain write port.
// ----------------------------------------------------------------------------
module kpc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [kpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [kpc_pkg::THRESH_W-1:0]       cfg_wr_data,
    output kpc_pkg::cfg_t                      cfg
);

    kpc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= kpc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= kpc_pkg::LONG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                kpc_pkg::REG_DEBOUNCE: cfg_reg.debounce_ticks   <= cfg_wr_data;
                kpc_pkg::REG_LONG:     cfg_reg.long_press_ticks <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/kpc_key_state.sv =====
// ----------------------------------------------------------------------------
// kpc_key_state
// Per-channel hold flag, start tick and pending action, with the classify
// and update of one polled channel, read and written in the same cycle.
// ----------------------------------------------------------------------------
module kpc_key_state #(
    parameter int KEY_COUNT = kpc_pkg::KEY_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fire,
    input  logic [kpc_pkg::KEY_IDX_W-1:0]     key_index,
    input  logic                              pin_level,
    input  logic [kpc_pkg::TICK_W-1:0]        now_tick,
    input  kpc_pkg::cfg_t                     cfg,
    output logic [kpc_pkg::EVENT_W-1:0]       key_event
);

    localparam int SEL_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic                            hold_reg    [KEY_COUNT];
    logic [kpc_pkg::TICK_W-1:0]      start_reg   [KEY_COUNT];
    logic [kpc_pkg::EVENT_W-1:0]     pending_reg [KEY_COUNT];

    logic [SEL_W-1:0]                sel;
    logic                            in_range;
    logic                            cur_hold;
    logic [kpc_pkg::TICK_W-1:0]      cur_start;
    logic [kpc_pkg::EVENT_W-1:0]     cur_pending;
    logic [kpc_pkg::TICK_W-1:0]      short_mark;
    logic [kpc_pkg::TICK_W-1:0]      long_mark;
    logic [kpc_pkg::EVENT_W-1:0]     pending_next;
    logic                            wr_en;

    assign in_range = 32'(key_index) < 32'(KEY_COUNT);
    assign sel      = SEL_W'(key_index);
    assign wr_en    = fire && in_range;

    assign cur_hold    = in_range ? hold_reg[sel]    : 1'b0;
    assign cur_start   = start_reg[sel];
    assign cur_pending = in_range ? pending_reg[sel] : kpc_pkg::EVT_NONE;

    // thresholds wrap at the tick width
    assign short_mark = cur_start + kpc_pkg::TICK_W'(cfg.debounce_ticks);
    assign long_mark  = cur_start + kpc_pkg::TICK_W'(cfg.long_press_ticks);

    always_comb begin
        pending_next = cur_pending;
        if (now_tick >= short_mark) begin
            pending_next = kpc_pkg::EVT_SHORT;
        end
        if (now_tick >= long_mark) begin
            pending_next = kpc_pkg::EVT_LONG;
        end
    end

    assign key_event = pin_level ? cur_pending : kpc_pkg::EVT_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                hold_reg[i]    <= 1'b0;
                pending_reg[i] <= kpc_pkg::EVT_NONE;
            end
        end else if (wr_en) begin
            if (pin_level) begin
                hold_reg[sel]    <= 1'b0;
                pending_reg[sel] <= kpc_pkg::EVT_NONE;
            end else if (!cur_hold) begin
                hold_reg[sel]    <= 1'b1;
            end else begin
                pending_reg[sel] <= pending_next;
            end
        end
    end

    // start tick is only read while the hold flag is set
    always_ff @(posedge aclk) begin
        if (wr_en && !pin_level && !cur_hold) begin
            start_reg[sel] <= now_tick;
        end
    end

`ifndef SYNTHESIS
    generate
        for (genvar g = 0; g < KEY_COUNT; g++) begin : g_chk
            a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
                !hold_reg[g] |-> pending_reg[g] == kpc_pkg::EVT_NONE)
                else $error("pending action without hold flag on channel %0d", g);
        end
    endgenerate

    a_low_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !pin_level |-> key_event == kpc_pkg::EVT_NONE)
        else $error("event reported on a low sample");

    a_out_of_range_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !in_range |-> key_event == kpc_pkg::EVT_NONE)
        else $error("event reported for an absent channel");
`endif

endmodule

// ===== design/key_press_classifier.sv =====
// data path: an accepted beat goes from the input register to the result one
// when that is free; one beat per cycle unless m_tready stalls the output;
// the channel state is read and updated in the same cycle, so consecutive
// polls of one channel follow back to back
// reset: synchronous active-low aresetn clears all hold flags and pending
// actions, empties both registers and loads thresholds of 20 and 500 ticks
// ----------------------------------------------------------------------------
// key_press_classifier
// Debounce and short/long press classification of polled active-low keys.
// ----------------------------------------------------------------------------
module key_press_classifier #(
    parameter int KEY_COUNT = kpc_pkg::KEY_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [kpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [kpc_pkg::THRESH_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key_index [1:0], pin_level [2], now_tick [34:3], zero pad
    input  logic [kpc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // key_event [1:0], zero pad
    output logic [kpc_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int PIN_BIT  = kpc_pkg::KEY_IDX_W;
    localparam int TICK_LSB = kpc_pkg::KEY_IDX_W + 1;

    kpc_pkg::cfg_t                      cfg;

    logic                               in_valid_reg;
    logic [kpc_pkg::KEY_IDX_W-1:0]      key_index_reg;
    logic                               pin_level_reg;
    logic [kpc_pkg::TICK_W-1:0]         now_tick_reg;

    logic                               out_valid_reg;
    logic [kpc_pkg::EVENT_W-1:0]        event_reg;

    logic                               out_free;
    logic                               fire;
    logic [kpc_pkg::EVENT_W-1:0]        event_next;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    kpc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    kpc_key_state #(
        .KEY_COUNT (KEY_COUNT)
    ) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .key_index (key_index_reg),
        .pin_level (pin_level_reg),
        .now_tick  (now_tick_reg),
        .cfg       (cfg),
        .key_event (event_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            key_index_reg <= s_tdata[kpc_pkg::KEY_IDX_W-1:0];
            pin_level_reg <= s_tdata[PIN_BIT];
            now_tick_reg  <= s_tdata[TICK_LSB +: kpc_pkg::TICK_W];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            event_reg <= event_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = kpc_pkg::M_TDATA_W'(event_reg);

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with a free register");

    a_fire_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed beat did not reach the result register");

    a_event_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> event_reg != 2'd3)
        else $error("illegal event code");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the key press classifier. Polls are streamed in with random
// gaps and back-pressure, a local model of the per-key timing predicts
// every key event, and each result beat is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 6;

    typedef struct packed {
        logic [kpc_pkg::TICK_W-1:0]    now_tick;
        logic                          pin_level;
        logic [kpc_pkg::KEY_IDX_W-1:0] key_index;
    } key_poll_t;

    typedef struct {
        key_poll_t                   poll;
        logic [kpc_pkg::EVENT_W-1:0] key_event;
    } key_outcome_t;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [kpc_pkg::CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [kpc_pkg::THRESH_W-1:0]   cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [kpc_pkg::S_TDATA_W-1:0]  s_tdata     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [kpc_pkg::M_TDATA_W-1:0]  m_tdata;

    // model of the per-key timing state
    logic                          key_held    [kpc_pkg::KEY_COUNT_DEF];
    logic [kpc_pkg::TICK_W-1:0]    press_tick  [kpc_pkg::KEY_COUNT_DEF];
    logic [kpc_pkg::EVENT_W-1:0]   held_action [kpc_pkg::KEY_COUNT_DEF];
    logic [kpc_pkg::THRESH_W-1:0]  debounce_cfg = kpc_pkg::DEBOUNCE_RESET;
    logic [kpc_pkg::THRESH_W-1:0]  long_cfg     = kpc_pkg::LONG_RESET;

    key_outcome_t outcome_queue[$];
    int           error_count   = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_off_req  = 1'b0;

    key_press_classifier uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [kpc_pkg::EVENT_W-1:0] classify_poll(input key_poll_t p);
        logic [kpc_pkg::TICK_W-1:0]  short_mark;
        logic [kpc_pkg::TICK_W-1:0]  long_mark;
        logic [kpc_pkg::EVENT_W-1:0] ev;
        ev = kpc_pkg::EVT_NONE;
        // both marks wrap at the tick width
        short_mark = press_tick[p.key_index] + kpc_pkg::TICK_W'(debounce_cfg);
        long_mark  = press_tick[p.key_index] + kpc_pkg::TICK_W'(long_cfg);
        if (!p.pin_level) begin
            if (!key_held[p.key_index]) begin
                key_held[p.key_index]   = 1'b1;
                press_tick[p.key_index] = p.now_tick;
            end else begin
                if (p.now_tick >= short_mark)
                    held_action[p.key_index] = kpc_pkg::EVT_SHORT;
                if (p.now_tick >= long_mark)
                    held_action[p.key_index] = kpc_pkg::EVT_LONG;
            end
        end else begin
            key_held[p.key_index]    = 1'b0;
            ev                       = held_action[p.key_index];
            held_action[p.key_index] = kpc_pkg::EVT_NONE;
        end
        return ev;
    endfunction

    task automatic send_poll(input logic [kpc_pkg::KEY_IDX_W-1:0] key, input logic pin,
                             input logic [kpc_pkg::TICK_W-1:0] tick);
        key_poll_t    p;
        key_outcome_t o;
        p.key_index = key;
        p.pin_level = pin;
        p.now_tick  = tick;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= kpc_pkg::S_TDATA_W'(p);
        do @(posedge aclk); while (!s_tready);
        o.poll      = p;
        o.key_event = classify_poll(p);
        outcome_queue.push_back(o);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (outcome_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [kpc_pkg::CFG_ADDR_W-1:0] addr,
                                   input logic [kpc_pkg::THRESH_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (addr)
            kpc_pkg::REG_DEBOUNCE: debounce_cfg = value;
            kpc_pkg::REG_LONG:     long_cfg     = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // offsets on and just below both thresholds, or random ones
    function automatic logic [kpc_pkg::TICK_W-1:0] pick_offset();
        logic [kpc_pkg::TICK_W-1:0] deb;
        logic [kpc_pkg::TICK_W-1:0] lng;
        deb = kpc_pkg::TICK_W'(debounce_cfg);
        lng = kpc_pkg::TICK_W'(long_cfg);
        case ($urandom_range(5))
            0: return deb - 1;
            1: return deb;
            2: return lng - 1;
            3: return lng;
            4: return $urandom_range((deb > lng ? deb : lng) + 10);
            default: return $urandom();
        endcase
    endfunction

    task automatic run_presses(input int n_items);
        int                            sent;
        int                            n_holds;
        logic [kpc_pkg::KEY_IDX_W-1:0] key;
        logic [kpc_pkg::TICK_W-1:0]    start;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 20) begin
                send_poll(kpc_pkg::KEY_IDX_W'($urandom_range(3)), 1'($urandom_range(1)),
                          $urandom());
                sent++;
            end else begin
                key   = kpc_pkg::KEY_IDX_W'($urandom_range(3));
                start = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(70000)
                                                 : $urandom();
                send_poll(key, 1'b0, start);
                n_holds = $urandom_range(1, 4);
                repeat (n_holds) send_poll(key, 1'b0, start + pick_offset());
                sent += n_holds + 1;
                // now and then the key is left held
                if ($urandom_range(9) != 0) begin
                    send_poll(key, 1'b1, $urandom());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_default_thresholds();
        send_poll(0, 1'b0, 100);
        send_poll(0, 1'b0, 119);
        send_poll(0, 1'b1, 130);
        send_poll(1, 1'b0, 1000);
        send_poll(1, 1'b0, 1020);
        send_poll(1, 1'b1, 1021);
        send_poll(2, 1'b0, 5);
        send_poll(2, 1'b0, 504);
        send_poll(2, 1'b0, 505);
        send_poll(2, 1'b1, 600);
        // release without a press, twice
        send_poll(3, 1'b1, 0);
        send_poll(3, 1'b1, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_tick_wrap();
        send_poll(0, 1'b0, 32'hFFFF_FFF0);
        send_poll(0, 1'b0, 32'h0000_0004);
        send_poll(0, 1'b1, 7);
        send_poll(3, 1'b0, 32'hFFFF_FFFF);
        send_poll(3, 1'b0, 32'h0000_01F3);
        send_poll(3, 1'b1, 0);
        wait_idle();
    endtask

    task automatic test_threshold_extremes();
        write_threshold(kpc_pkg::REG_DEBOUNCE, 16'd0);
        write_threshold(kpc_pkg::REG_LONG, 16'd0);
        send_poll(1, 1'b0, 42);
        send_poll(1, 1'b0, 42);
        send_poll(1, 1'b1, 42);
        wait_idle();
        write_threshold(kpc_pkg::REG_DEBOUNCE, 16'hFFFF);
        write_threshold(kpc_pkg::REG_LONG, 16'hFFFF);
        send_poll(2, 1'b0, 0);
        send_poll(2, 1'b0, 65534);
        send_poll(2, 1'b0, 65535);
        send_poll(2, 1'b1, 1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_threshold(kpc_pkg::REG_DEBOUNCE, 16'd20);
        write_threshold(kpc_pkg::REG_LONG, 16'd500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        run_presses(40);
        // sender waits for the pipeline to empty, then resumes
        wait_idle();
        run_presses(12);
        wait_idle();
    endtask

    task automatic test_random_presses();
        logic [kpc_pkg::THRESH_W-1:0] deb_set [6];
        logic [kpc_pkg::THRESH_W-1:0] lng_set [6];
        deb_set = '{16'd3, 16'd0, 16'hFFFF, 16'd100, 16'd0, 16'd0};
        lng_set = '{16'd40, 16'd0, 16'hFFFF, 16'd50, 16'd0, 16'd0};
        deb_set[4] = kpc_pkg::THRESH_W'($urandom_range(16'hFFFF));
        lng_set[4] = kpc_pkg::THRESH_W'($urandom_range(16'hFFFF));
        deb_set[5] = kpc_pkg::THRESH_W'($urandom_range(300));
        lng_set[5] = kpc_pkg::THRESH_W'($urandom_range(2000));
        for (int i = 0; i < 6; i++) begin
            case (i / 2)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_threshold(kpc_pkg::REG_DEBOUNCE, deb_set[i]);
            write_threshold(kpc_pkg::REG_LONG, lng_set[i]);
            run_presses(165);
            wait_idle();
        end
    endtask

    // result side: random ready, with one long hold-off on request
    initial begin : drive_ready
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_events
        key_outcome_t o;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, key_event %0d",
                                          m_tdata[kpc_pkg::EVENT_W-1:0]));
            end else begin
                o = outcome_queue.pop_front();
                if (m_tdata[kpc_pkg::EVENT_W-1:0] !== o.key_event)
                    report_mismatch($sformatf("key %0d pin %0d tick %0h: event %0d, want %0d",
                                              o.poll.key_index, o.poll.pin_level,
                                              o.poll.now_tick,
                                              m_tdata[kpc_pkg::EVENT_W-1:0],
                                              o.key_event));
            end
        end
    end

    initial begin
        for (int k = 0; k < kpc_pkg::KEY_COUNT_DEF; k++) begin
            key_held[k]    = 1'b0;
            press_tick[k]  = '0;
            held_action[k] = kpc_pkg::EVT_NONE;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_thresholds();
        test_tick_wrap();
        test_threshold_extremes();
        test_backpressure();
        test_random_presses();
        wait_idle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== key_press_classifier.f =====
design/kpc_pkg.sv
design/kpc_cfg_regs.sv
design/kpc_key_state.sv
design/key_press_classifier.sv
bench/tb_top.sv
